[rtl/core/fdl_pkg.sv]
// Package for the fractional delay line: operation codes, register indexes,
// default sizes and the memory request type. No dependencies.
package fdl_pkg;

  localparam int unsigned DefaultDepth = 4096;
  localparam int unsigned DefaultSampleBits = 24;
  localparam int unsigned DefaultFractionBits = 16;

  localparam int unsigned OpBits = 3;
  localparam int unsigned DelayBits = 12;
  localparam int unsigned CoefBits = 16;
  localparam int unsigned CoefShift = 15;
  localparam int unsigned CfgIndexBits = 1;
  // Register write data is wide enough for the wider of the two registers.
  localparam int unsigned CfgDataBits = 16;

  typedef enum logic [OpBits-1:0] {
    OpWrite     = 3'd0,
    OpReadFixed = 3'd1,
    OpReadLin   = 3'd2,
    OpReadHerm  = 3'd3,
    OpAllpass   = 3'd4
  } op_e;

  localparam logic [CfgIndexBits-1:0] RegDelayWhole = 1'b0;
  localparam logic [CfgIndexBits-1:0] RegDelayFraction = 1'b1;

  // Memory request from the sequencer to the sample store.
  typedef struct packed {
    logic        en;
    logic        we;
  } mem_ctl_t;

endpackage

[rtl/core/fractional_delay_line.sv]
// Fractional delay line with linear and Hermite interpolation and allpass.
// Reads and allpass pass StRd, StCap, then StLin, StH1-StH3 or StAp1-StAp3, then
// StOut, which raises result valid; a write completes in its own transfer cycle.
// Throughput: one item at a time; the single-port sample store sets the pace
// (one access per cycle: up to four reads for Hermite, read plus write for allpass).
// Reset: a clearing pass zeroes the whole store; no input is taken then.
// Configuration resets to whole delay 1, fraction 0. Depends on fdl_pkg, fdl_store.
module fractional_delay_line #(
  parameter int unsigned Depth = fdl_pkg::DefaultDepth,
  parameter int unsigned SampleBits = fdl_pkg::DefaultSampleBits,
  parameter int unsigned FractionBits = fdl_pkg::DefaultFractionBits,
  localparam int unsigned AddrBits = $clog2(Depth)
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [fdl_pkg::OpBits-1:0]           operation_i,
  input  logic signed [SampleBits-1:0]         sample_in_i,
  input  logic [fdl_pkg::DelayBits-1:0]        delay_whole_i,
  input  logic [FractionBits-1:0]              delay_fraction_i,
  input  logic signed [fdl_pkg::CoefBits-1:0]  allpass_coefficient_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [SampleBits-1:0]         sample_out_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [fdl_pkg::CfgIndexBits-1:0]     cfg_index_i,
  input  logic [fdl_pkg::CfgDataBits-1:0]      cfg_data_i
);

  // Working width: Hermite terms reach about 16x sample range plus a fraction product.
  localparam int unsigned WBits = SampleBits + 6;
  localparam int unsigned PBits = WBits + FractionBits + 1;
  localparam logic signed [WBits-1:0] SatHi = WBits'((64'sd1 <<< (SampleBits - 1)) - 1);
  localparam logic signed [WBits-1:0] SatLo = -SatHi - WBits'(1);
  localparam logic [fdl_pkg::DelayBits-1:0] MaxWhole =
      (Depth - 1 > 4095) ? 12'hFFF : fdl_pkg::DelayBits'(Depth - 1);

  typedef enum logic [3:0] {
    StIdle, StRd, StCap, StH1, StH2, StH3, StLin, StAp1, StAp2, StAp3, StOut
  } state_e;

  state_e                         state_q;
  logic [fdl_pkg::OpBits-1:0]     op_q;
  logic signed [SampleBits-1:0]   smp_q;
  logic [AddrBits-1:0]            base_q, wpos_q;
  logic [FractionBits-1:0]        frac_q, cfg_frac_q;
  logic [fdl_pkg::DelayBits-1:0]  cfg_whole_q;
  logic signed [fdl_pkg::CoefBits-1:0] coef_q;
  logic [2:0]                     rd_cnt_q, cap_cnt_q, nreads_q;
  logic                           cap_q;
  logic signed [WBits-1:0]        x_q [4];
  logic signed [WBits-1:0]        acc_q, b2_q, c2_q;
  logic signed [SampleBits-1:0]   res_q;
  logic                           out_valid_q;

  fdl_pkg::mem_ctl_t              mem_ctl;
  logic [AddrBits-1:0]            mem_addr;
  logic [SampleBits-1:0]          mem_wdata, mem_rdata;
  logic                           clr_busy;

  fdl_store #(.Depth(Depth), .SampleBits(SampleBits)) u_store (
    .clk_i, .rst_ni, .ctl_i(mem_ctl), .addr_i(mem_addr), .wdata_i(mem_wdata),
    .rdata_o(mem_rdata), .clear_busy_o(clr_busy)
  );

  function automatic logic signed [WBits-1:0] sat(input logic signed [WBits-1:0] v);
    if (v > SatHi) return SatHi;
    if (v < SatLo) return SatLo;
    return v;
  endfunction

  // One shared multiplier: acc or a sample times fraction or coefficient, shifted down.
  logic signed [WBits-1:0]   mul_a;
  logic signed [FractionBits+1:0] mul_b;
  logic signed [PBits+1:0]   prod;
  assign prod = (PBits+2)'(mul_a) * (PBits+2)'(mul_b);

  assign in_ready_o = (state_q == StIdle) && !clr_busy && !out_valid_q;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign sample_out_o = res_q;

  // Memory address: reads are base + offset-1 for Hermite, base + offset otherwise.
  logic [AddrBits-1:0] rd_addr;
  always_comb begin
    if (op_q == fdl_pkg::OpReadHerm) begin
      rd_addr = base_q + AddrBits'(rd_cnt_q) - AddrBits'(1);
    end else begin
      rd_addr = base_q + AddrBits'(rd_cnt_q);
    end
    mem_ctl = '0;
    mem_addr = rd_addr;
    mem_wdata = acc_q[SampleBits-1:0];
    if (state_q == StRd) begin
      mem_ctl.en = 1'b1;
    end else if (state_q == StIdle && in_valid_i && in_ready_o &&
                 operation_i == fdl_pkg::OpWrite) begin
      mem_ctl = '{en: 1'b1, we: 1'b1};
      mem_addr = wpos_q;
      mem_wdata = sample_in_i;
    end else if (state_q == StAp2) begin
      mem_ctl = '{en: 1'b1, we: 1'b1};
      mem_addr = wpos_q;
    end
  end

  always_comb begin
    mul_a = acc_q;
    mul_b = (FractionBits+2)'({1'b0, frac_q});
    if (state_q == StAp1) begin
      mul_a = x_q[0];
      mul_b = (FractionBits+2)'(coef_q);
    end else if (state_q == StAp3) begin
      mul_b = (FractionBits+2)'(coef_q);
    end
  end

  logic signed [WBits-1:0] fl_f, rd_c, diff;
  assign fl_f = WBits'(prod >>> FractionBits);
  assign rd_c = WBits'((prod + (PBits+2)'(1 <<< (fdl_pkg::CoefShift - 1))) >>>
                       fdl_pkg::CoefShift);
  assign diff = x_q[1] - x_q[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      out_valid_q <= 1'b0;
      wpos_q <= '0;
      cfg_whole_q <= fdl_pkg::DelayBits'(1);
      cfg_frac_q <= '0;
      cap_q <= 1'b0;
      rd_cnt_q <= '0;
      cap_cnt_q <= '0;
      nreads_q <= '0;
      op_q <= '0;
    end else begin
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      if (cfg_valid_i) begin
        if (cfg_index_i == fdl_pkg::RegDelayWhole) begin
          cfg_whole_q <= (cfg_data_i > fdl_pkg::CfgDataBits'(MaxWhole)) ? MaxWhole :
                         cfg_data_i[fdl_pkg::DelayBits-1:0];
        end else begin
          cfg_frac_q <= FractionBits'(cfg_data_i);
        end
      end
      // Capture happens in the cycle after the read request.
      cap_q <= (state_q == StRd);
      if (cap_q) begin
        x_q[cap_cnt_q[1:0]] <= WBits'($signed(mem_rdata));
        cap_cnt_q <= cap_cnt_q + 3'd1;
      end
      unique case (state_q)
        StIdle: begin
          if (in_valid_i && in_ready_o) begin
            op_q <= operation_i;
            smp_q <= sample_in_i;
            coef_q <= allpass_coefficient_i;
            rd_cnt_q <= '0;
            cap_cnt_q <= '0;
            if (operation_i == fdl_pkg::OpReadFixed) begin
              base_q <= wpos_q + AddrBits'(cfg_whole_q);
              frac_q <= cfg_frac_q;
            end else begin
              base_q <= wpos_q + AddrBits'(delay_whole_i);
              frac_q <= delay_fraction_i;
            end
            priority if (operation_i == fdl_pkg::OpWrite) begin
              wpos_q <= wpos_q - AddrBits'(1);
            end else if (operation_i == fdl_pkg::OpReadFixed ||
                         operation_i == fdl_pkg::OpReadLin) begin
              nreads_q <= 3'd2;
              state_q <= StRd;
            end else if (operation_i == fdl_pkg::OpReadHerm) begin
              nreads_q <= 3'd4;
              state_q <= StRd;
            end else if (operation_i == fdl_pkg::OpAllpass) begin
              nreads_q <= 3'd1;
              state_q <= StRd;
            end else begin
              // Unused codes make no result and leave the store and write position alone.
              state_q <= StIdle;
            end
          end
        end
        StRd: begin
          rd_cnt_q <= rd_cnt_q + 3'd1;
          if (rd_cnt_q + 3'd1 == nreads_q) state_q <= StCap;
        end
        StCap: begin
          if (!cap_q) begin
            priority if (op_q == fdl_pkg::OpAllpass) begin
              state_q <= StAp1;
            end else if (op_q == fdl_pkg::OpReadHerm) begin
              // x_q: 0 = x[-1], 1 = x0, 2 = x1, 3 = x2; coefficients at twice scale.
              c2_q <= x_q[2] - x_q[0];
              b2_q <= ((x_q[2] - x_q[0]) <<< 1) + ((x_q[1] - x_q[2]) <<< 2)
                      + (x_q[1] - x_q[2]) + (x_q[1] - x_q[2]) + (x_q[3] - x_q[1]);
              acc_q <= (x_q[2] - x_q[0]) + ((x_q[1] - x_q[2]) <<< 2) + (x_q[3] - x_q[1]);
              state_q <= StH1;
            end else begin
              acc_q <= diff;
              state_q <= StLin;
            end
          end
        end
        StLin: begin
          res_q <= SampleBits'(sat(x_q[0] + WBits'((prod +
                   (PBits+2)'(1 <<< (FractionBits - 1))) >>> FractionBits)));
          state_q <= StOut;
        end
        StH1: begin
          acc_q <= fl_f - b2_q;
          state_q <= StH2;
        end
        StH2: begin
          acc_q <= fl_f + c2_q;
          state_q <= StH3;
        end
        StH3: begin
          res_q <= SampleBits'(sat((fl_f + (x_q[1] <<< 1) + WBits'(1)) >>> 1));
          state_q <= StOut;
        end
        StAp1: begin
          acc_q <= sat(WBits'(smp_q) + rd_c);
          state_q <= StAp2;
        end
        StAp2: begin
          wpos_q <= wpos_q - AddrBits'(1);
          state_q <= StAp3;
        end
        StAp3: begin
          res_q <= SampleBits'(sat(x_q[0] - rd_c));
          state_q <= StOut;
        end
        StOut: begin
          out_valid_q <= 1'b1;
          state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_no_input_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StIdle) |-> !in_ready_o) else $error("input taken while busy");
  a_no_input_during_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy |-> !in_ready_o) else $error("input taken during clear");
  a_result_from_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == StOut)) else $error("stray result");
  a_write_steps_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_ctl.we && state_q == StIdle) |=> (wpos_q == $past(wpos_q) - AddrBits'(1)))
    else $error("write position not stepped");
`endif

endmodule

[rtl/core/fdl_store.sv]
// Sample store: single-port synchronous memory with registered read data
// and a clearing pass after reset. Depends on fdl_pkg.
module fdl_store #(
  parameter int unsigned Depth = fdl_pkg::DefaultDepth,
  parameter int unsigned SampleBits = fdl_pkg::DefaultSampleBits,
  localparam int unsigned AddrBits = $clog2(Depth)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  fdl_pkg::mem_ctl_t     ctl_i,
  input  logic [AddrBits-1:0]   addr_i,
  input  logic [SampleBits-1:0] wdata_i,
  output logic [SampleBits-1:0] rdata_o,
  output logic                  clear_busy_o
);

  logic [SampleBits-1:0] mem [Depth];
  logic [AddrBits-1:0]   clr_addr_q, clr_addr_d;
  logic                  busy_q, busy_d;

  always_comb begin
    clr_addr_d = clr_addr_q;
    busy_d = busy_q;
    if (busy_q) begin
      clr_addr_d = clr_addr_q + AddrBits'(1);
      if (clr_addr_q == AddrBits'(Depth - 1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q <= '0;
      busy_q <= 1'b1;
    end else begin
      clr_addr_q <= clr_addr_d;
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      mem[clr_addr_q] <= '0;
    end else if (ctl_i.en) begin
      if (ctl_i.we) begin
        mem[addr_i] <= wdata_i;
      end else begin
        rdata_o <= mem[addr_i];
      end
    end
  end

  assign clear_busy_o = busy_q;

endmodule

[bench/fdl_checker.sv]
`timescale 1ns / 1ps
// Checker for the fractional delay line: watches the input, output and
// register channels, predicts each result and compares it. Depends on fdl_pkg.
module fdl_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic [2:0]         operation_i,
  input  logic signed [23:0] sample_in_i,
  input  logic [11:0]        delay_whole_i,
  input  logic [15:0]        delay_fraction_i,
  input  logic signed [15:0] allpass_coefficient_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic signed [23:0] sample_out_i,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [0:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  output int                 fail_count_o,
  output int                 pending_o
);

  localparam longint SampleMax = 64'sd8388607;
  localparam longint SampleMin = -64'sd8388608;

  logic signed [23:0] delay_mem [4096];
  logic [11:0]        wr_pos;
  logic [11:0]        cfg_whole;
  logic [15:0]        cfg_fraction;
  logic signed [23:0] expected_samples [$];

  assign pending_o = expected_samples.size();

  function automatic longint sat(longint v);
    if (v > SampleMax) return SampleMax;
    if (v < SampleMin) return SampleMin;
    return v;
  endfunction

  function automatic longint rnd_shift(longint v, int n);
    return (v + (64'sd1 <<< (n - 1))) >>> n;
  endfunction

  function automatic longint tap(logic [11:0] d, logic [11:0] offset);
    logic [11:0] idx;
    idx = wr_pos + d + offset;
    return longint'(delay_mem[idx]);
  endfunction

  function automatic longint lerp_at(logic [11:0] d, longint f);
    longint a, b;
    a = tap(d, 12'd0);
    b = tap(d, 12'd1);
    return sat(a + rnd_shift((b - a) * f, 16));
  endfunction

  function automatic longint hermite_at(logic [11:0] d, longint f);
    longint xm1, x0, x1, x2, c2, v2, w2, a2, b2, t;
    xm1 = tap(d, 12'd4095);
    x0  = tap(d, 12'd0);
    x1  = tap(d, 12'd1);
    x2  = tap(d, 12'd2);
    c2 = x1 - xm1;
    v2 = 2 * (x0 - x1);
    w2 = c2 + v2;
    a2 = w2 + v2 + (x2 - x0);
    b2 = w2 + a2;
    t = ((a2 * f) >>> 16) - b2;
    t = ((t * f) >>> 16) + c2;
    t = ((t * f) >>> 16) + 2 * x0;
    return sat(rnd_shift(t, 1));
  endfunction

  function automatic void push_sample(longint v);
    delay_mem[wr_pos] = 24'(sat(v));
    wr_pos = wr_pos - 12'd1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    longint rd, wr, res;
    logic signed [23:0] exp_s;
    bit has_result;
    if (!rst_ni) begin
      foreach (delay_mem[i]) delay_mem[i] = '0;
      wr_pos = '0;
      cfg_whole = 12'd1;
      cfg_fraction = '0;
      fail_count_o = 0;
      expected_samples.delete();
    end else begin
      // Results are compared before this edge's input is predicted; one item
      // is in flight at a time, so order is never in question.
      if (out_valid_i && out_ready_i) begin
        if (expected_samples.size() == 0) begin
          $error("sample_out: unexpected result %0d", sample_out_i);
          fail_count_o++;
        end else begin
          exp_s = expected_samples.pop_front();
          if (sample_out_i !== exp_s) begin
            $error("sample_out: expected %0d, actual %0d", exp_s, sample_out_i);
            fail_count_o++;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == fdl_pkg::RegDelayWhole) begin
          cfg_whole = (cfg_data_i > 16'd4095) ? 12'd4095 : cfg_data_i[11:0];
        end else begin
          cfg_fraction = cfg_data_i;
        end
      end
      if (in_valid_i && in_ready_i) begin
        has_result = 1'b1;
        case (operation_i)
          fdl_pkg::OpWrite: begin
            push_sample(longint'(sample_in_i));
            has_result = 1'b0;
          end
          fdl_pkg::OpReadFixed: res = lerp_at(cfg_whole, longint'(cfg_fraction));
          fdl_pkg::OpReadLin:   res = lerp_at(delay_whole_i, longint'(delay_fraction_i));
          fdl_pkg::OpReadHerm:  res = hermite_at(delay_whole_i, longint'(delay_fraction_i));
          fdl_pkg::OpAllpass: begin
            rd = tap(delay_whole_i, 12'd0);
            wr = sat(longint'(sample_in_i) +
                     rnd_shift(longint'(allpass_coefficient_i) * rd, fdl_pkg::CoefShift));
            push_sample(wr);
            res = sat(rd - rnd_shift(wr * longint'(allpass_coefficient_i),
                                     fdl_pkg::CoefShift));
          end
          default: has_result = 1'b0;
        endcase
        if (has_result) expected_samples.push_back(24'(res));
      end
    end
  end

endmodule

[bench/fractional_delay_line_tb.sv]
`timescale 1ns / 1ps
// Top of the fractional delay line bench: clock, reset, stimulus and verdict.
// Depends on fdl_pkg, fractional_delay_line and fdl_checker.
module fractional_delay_line_tb;

  // Codes 5 to 7 are not operations; the block must drop them silently.
  localparam logic [2:0] FirstUnusedOp = 3'd5;
  localparam logic [2:0] LastUnusedOp  = 3'd7;
  // Writes make no result, so before a register write or the verdict the
  // bench waits out a margin longer than any operation of the block.
  localparam int DrainCycles = 24;
  localparam int HoldCycles  = 400;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [2:0]         operation;
  logic signed [23:0] sample_in;
  logic [11:0]        delay_whole;
  logic [15:0]        delay_fraction;
  logic signed [15:0] allpass_coef;
  logic               out_valid;
  logic               out_ready;
  logic signed [23:0] sample_out;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [0:0]         cfg_index;
  logic [15:0]        cfg_data;
  int                 fail_count;
  int                 pending;

  // Idling is turned off for one stretch of the run; the receiver hold-off
  // is requested by the stimulus and counted by the receiver itself.
  bit                 no_idle;
  bit                 hold_request;

  fractional_delay_line u_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .operation_i(operation), .sample_in_i(sample_in),
    .delay_whole_i(delay_whole), .delay_fraction_i(delay_fraction),
    .allpass_coefficient_i(allpass_coef),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .sample_out_o(sample_out),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  fdl_checker u_checker (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_i(in_ready),
    .operation_i(operation), .sample_in_i(sample_in),
    .delay_whole_i(delay_whole), .delay_fraction_i(delay_fraction),
    .allpass_coefficient_i(allpass_coef),
    .out_valid_i(out_valid), .out_ready_i(out_ready), .sample_out_i(sample_out),
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Generous fixed limit: the reset clearing pass, 820 items, random gaps
  // and the long hold-off together come well under a tenth of this.
  initial begin
    #5ms;
    $display("fractional_delay_line regression: fail");
    $finish;
  end

  // Receiver: random back-pressure, or a long hold-off when one is asked.
  initial begin
    int hold_left;
    hold_left = 0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= no_idle || ($urandom_range(0, 99) >= 35);
      end
    end
  end

  // One input transfer. Valid stays high across back-to-back items and is
  // lowered only when the sender decides to idle before the next one.
  task automatic send_item(logic [2:0] op, logic signed [23:0] s, logic [11:0] dw,
                           logic [15:0] df, logic signed [15:0] c);
    while (!no_idle && $urandom_range(0, 99) < 35) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    operation      <= op;
    sample_in      <= s;
    delay_whole    <= dw;
    delay_fraction <= df;
    allpass_coef   <= c;
    do @(posedge clk); while (!in_ready);
  endtask

  // Lower valid and wait until every predicted result has been checked,
  // then let any trailing write finish inside the block.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic signed [23:0] pick_sample();
    case ($urandom_range(0, 9))
      0: return 24'sh7FFFFF;
      1: return 24'sh800000;
      2: return 24'($urandom_range(0, 15)) - 24'sd8;
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic logic [11:0] pick_delay();
    // Mostly near the write position so reads see freshly written samples.
    if ($urandom_range(0, 3) == 0) return 12'($urandom);
    return 12'($urandom_range(0, 12));
  endfunction

  // Random item: writes as the largest share, mixed with every kind of read
  // and allpass, a few unused codes as noise.
  task automatic random_item();
    logic [2:0] op;
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 40)      op = fdl_pkg::OpWrite;
    else if (sel < 52) op = fdl_pkg::OpReadFixed;
    else if (sel < 67) op = fdl_pkg::OpReadLin;
    else if (sel < 82) op = fdl_pkg::OpReadHerm;
    else if (sel < 96) op = fdl_pkg::OpAllpass;
    else               op = 3'($urandom_range(FirstUnusedOp, LastUnusedOp));
    send_item(op, pick_sample(), pick_delay(), 16'($urandom), 16'($urandom));
  endtask

  initial begin
    logic [15:0] whole_set [4];
    logic [15:0] frac_set [4];
    in_valid       = 1'b0;
    operation      = fdl_pkg::OpWrite;
    sample_in      = '0;
    delay_whole    = '0;
    delay_fraction = '0;
    allpass_coef   = '0;
    cfg_valid      = 1'b0;
    cfg_index      = fdl_pkg::RegDelayWhole;
    cfg_data       = '0;
    no_idle        = 1'b0;
    hold_request   = 1'b0;
    rst_n          = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part under the reset settings: reads of the cleared store,
    // extreme samples, both fraction extremes, wrap of the delay past the
    // end of the store, saturating Hermite and allpass, and unused codes.
    send_item(fdl_pkg::OpReadFixed, '0, '0, '0, '0);
    send_item(fdl_pkg::OpReadHerm, '0, 12'd4095, 16'hFFFF, '0);
    send_item(fdl_pkg::OpWrite, 24'sh7FFFFF, '0, '0, '0);
    send_item(fdl_pkg::OpWrite, 24'sh800000, '0, '0, '0);
    send_item(fdl_pkg::OpWrite, 24'sh7FFFFF, '0, '0, '0);
    send_item(fdl_pkg::OpWrite, 24'sh800000, '0, '0, '0);
    send_item(fdl_pkg::OpReadFixed, '0, '0, '0, '0);
    send_item(fdl_pkg::OpReadLin, '0, 12'd0, 16'h0000, '0);
    send_item(fdl_pkg::OpReadLin, '0, 12'd1, 16'hFFFF, '0);
    send_item(fdl_pkg::OpReadLin, '0, 12'd4095, 16'h8000, '0);
    send_item(fdl_pkg::OpReadHerm, '0, 12'd1, 16'h8000, '0);
    send_item(fdl_pkg::OpReadHerm, '0, 12'd2, 16'hFFFF, '0);
    send_item(fdl_pkg::OpReadHerm, '0, 12'd0, 16'h0001, '0);
    send_item(fdl_pkg::OpAllpass, 24'sh7FFFFF, 12'd1, '0, 16'sh7FFF);
    send_item(fdl_pkg::OpAllpass, 24'sh800000, 12'd2, '0, 16'sh8000);
    send_item(fdl_pkg::OpAllpass, 24'sh123456, 12'd4095, '0, 16'sh0000);
    send_item(FirstUnusedOp, 24'sh7FFFFF, 12'd1, 16'hFFFF, 16'sh7FFF);
    send_item(3'd6, '0, '0, '0, '0);
    send_item(LastUnusedOp, 24'sh800000, 12'hFFF, '0, 16'sh8000);
    send_item(fdl_pkg::OpReadFixed, '0, '0, '0, '0);
    drain();

    // Each phase sets both registers, extremes first (an oversized whole
    // delay is clamped), then runs random items.
    whole_set = '{16'd0, 16'hFFFF, 16'd1, 16'($urandom_range(2, 9))};
    frac_set  = '{16'd0, 16'hFFFF, 16'h8000, 16'($urandom)};
    for (int phase = 0; phase < 4; phase++) begin
      write_reg(fdl_pkg::RegDelayWhole, whole_set[phase]);
      write_reg(fdl_pkg::RegDelayFraction, frac_set[phase]);
      no_idle = (phase == 2);
      for (int n = 0; n < 200; n++) begin
        // The receiver stops for a long while and the block backs up.
        if (phase == 1 && n == 50) hold_request = 1'b1;
        // The sender stops until every result is in.
        if (phase == 3 && n == 100) begin
          in_valid <= 1'b0;
          @(posedge clk);
          while (pending != 0) @(posedge clk);
        end
        random_item();
      end
      drain();
    end
    no_idle = 1'b0;

    if (fail_count == 0 && pending == 0) begin
      $display("fractional_delay_line regression: pass");
    end else begin
      $display("fractional_delay_line regression: fail");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/core/fdl_pkg.sv
rtl/core/fdl_store.sv
rtl/core/fractional_delay_line.sv
bench/fdl_checker.sv
bench/fractional_delay_line_tb.sv
